// ===== hw/rtl/pdq_pkg.sv =====
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants for the positional deque.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int OpW      = 4;
  localparam int ValW     = 32;
  localparam int PosW     = 7;
  localparam int StW      = 2;
  localparam int CountW   = 7;
  localparam int InTdataW  = 48;  // 4 + 32 + 7 = 43, padded to bytes
  localparam int OutTdataW = 48;  // 32 + 2 + 7 + 1 = 42, padded to bytes

  typedef enum logic [OpW-1:0] {
    OpPushBack  = 4'd0,
    OpPushFront = 4'd1,
    OpPopFront  = 4'd2,
    OpPopBack   = 4'd3,
    OpInsertAt  = 4'd4,
    OpRemoveAt  = 4'd5,
    OpReadFront = 4'd6,
    OpReadBack  = 4'd7,
    OpReadAt    = 4'd8
  } pdq_op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StRange = 2'd3
  } pdq_status_e;

  // Broadcast to every cell: open a gap at pos (ins) or close one at pos (rem).
  typedef struct packed {
    logic ins;
    logic rem;
  } pdq_cmd_t;

endpackage

// ===== hw/rtl/positional_deque.sv =====
// ----------------------------------------------------------------------------
// positional_deque
// Bounded deque with push/pop at both ends and insert/remove/read at a
// position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Results: each accepted input beat yields a registered result beat in the next cycle.
// Throughput: 1 operation per cycle while the result sink does not stall; every cell
// shifts in the same cycle, so positional insert and remove cost no more than a push.
// Reset: the entry count clears to zero and the output goes idle; cell
// contents are undefined until written.
module positional_deque #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [3:0] opcode, [35:4] value, [42:36] position
  input  logic [pdq_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] read_data, [33:32] status, [40:34] entry_count, [41] is_empty
  output logic [pdq_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import pdq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int XW   = (DATA_WIDTH > ValW) ? DATA_WIDTH : ValW;
  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);
  localparam logic [CntW-1:0] One = CntW'(1);

  logic [OpW-1:0]  opcode;
  logic [ValW-1:0] value;
  logic [PosW-1:0] position;

  assign opcode   = s_axis_tdata_i[OpW-1:0];
  assign value    = s_axis_tdata_i[OpW+ValW-1:OpW];
  assign position = s_axis_tdata_i[OpW+ValW+PosW-1:OpW+ValW];

  logic [CntW-1:0] count_q, count_d;
  logic            m_valid_q;
  logic [ValW-1:0] rd_q;
  pdq_status_e     st_q;
  logic [CntW-1:0] cnt_out_q;

  logic s_fire;
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  logic [XW-1:0]         val_x;
  logic [DATA_WIDTH-1:0] wdata;
  logic [CmpW-1:0]       pos_x, cnt_x;
  logic [CntW-1:0]       pos_n;
  assign val_x = XW'(value);
  assign wdata = val_x[DATA_WIDTH-1:0];
  assign pos_x = CmpW'(position);
  assign cnt_x = CmpW'(count_q);
  assign pos_n = pos_x[CntW-1:0];

  logic full, empty;
  assign full  = (count_q == Cap);
  assign empty = (count_q == '0);

  pdq_cmd_t        cmd;
  logic [CntW-1:0] cmd_pos, rpos;
  logic            rd_en;
  pdq_status_e     st;

  always_comb begin
    cmd     = '0;
    cmd_pos = '0;
    rpos    = '0;
    rd_en   = 1'b0;
    st      = StOk;
    count_d = count_q;
    unique case (pdq_op_e'(opcode))
      OpPushBack: begin
        if (full) st = StFull;
        else begin
          cmd.ins = 1'b1;
          cmd_pos = count_q;
          count_d = count_q + One;
        end
      end
      OpPushFront: begin
        if (full) st = StFull;
        else begin
          cmd.ins = 1'b1;
          count_d = count_q + One;
        end
      end
      OpPopFront: begin
        if (empty) st = StEmpty;
        else begin
          cmd.rem = 1'b1;
          count_d = count_q - One;
        end
      end
      OpPopBack: begin
        if (empty) st = StEmpty;
        else count_d = count_q - One;
      end
      OpInsertAt: begin
        if (full) st = StFull;
        else if (pos_x > cnt_x) st = StRange;
        else begin
          cmd.ins = 1'b1;
          cmd_pos = pos_n;
          count_d = count_q + One;
        end
      end
      OpRemoveAt: begin
        if (empty) st = StEmpty;
        else if (pos_x >= cnt_x) st = StRange;
        else begin
          cmd.rem = 1'b1;
          cmd_pos = pos_n;
          count_d = count_q - One;
        end
      end
      OpReadFront: begin
        if (empty) st = StEmpty;
        else rd_en = 1'b1;
      end
      OpReadBack: begin
        if (empty) st = StEmpty;
        else begin
          rd_en = 1'b1;
          rpos  = count_q - One;
        end
      end
      OpReadAt: begin
        if (empty) st = StEmpty;
        else if (pos_x >= cnt_x) st = StRange;
        else begin
          rd_en = 1'b1;
          rpos  = pos_n;
        end
      end
      default: ;
    endcase
    if (!s_fire) begin
      cmd     = '0;
      count_d = count_q;
    end
  end

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_p
      assign prev_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_n
      assign next_w = cell_data[k+1];
    end
    pdq_cell #(
      .DataW (DATA_WIDTH),
      .CntW  (CntW),
      .Idx   (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cmd_pos),
      .wdata_i (wdata),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .rpos_i  (rpos),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  logic [DATA_WIDTH-1:0] rd_bus;
  logic [XW-1:0]         rd_x;
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end
  assign rd_x = rd_en ? XW'(rd_bus) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      rd_q      <= rd_x[ValW-1:0];
      st_q      <= st;
      cnt_out_q <= count_d;
    end
  end

  logic [CmpW-1:0] cnt_out_x;
  assign cnt_out_x = CmpW'(cnt_out_q);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {
    {(OutTdataW - ValW - StW - CountW - 1){1'b0}},
    (cnt_out_q == '0),
    cnt_out_x[CountW-1:0],
    st_q,
    rd_q
  };

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_fire |=> $stable(count_q))
    else $error("entry count moved without an input beat");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (opcode == OpPushBack) && !full |=> count_q == $past(count_q) + One)
    else $error("push did not grow the count");

  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (st != StOk) |=> $stable(count_q))
    else $error("failed operation changed the count");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

endmodule

// ===== hw/rtl/pdq_cell.sv =====
// ----------------------------------------------------------------------------
// pdq_cell
// One storage slot of the deque row. Shifts toward the back on insert,
// toward the front on remove, and drives the read bus when selected.
// ----------------------------------------------------------------------------
module pdq_cell #(
  parameter int DataW = 32,
  parameter int CntW  = 7,
  parameter int Idx   = 0
) (
  input  logic             clk_i,
  input  pdq_pkg::pdq_cmd_t cmd_i,
  input  logic [CntW-1:0]  pos_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [DataW-1:0] prev_i,
  input  logic [DataW-1:0] next_i,
  input  logic [CntW-1:0]  rpos_i,
  output logic [DataW-1:0] data_o,
  output logic [DataW-1:0] rd_o
);
  import pdq_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyIdx == pos_i) begin
        data_d = wdata_i;
      end else if (MyIdx > pos_i) begin
        data_d = prev_i;
      end
    end else if (cmd_i.rem) begin
      if (MyIdx >= pos_i) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyIdx == rpos_i) ? data_q : '0;

endmodule

// ===== tb/sv/positional_deque_tb.sv =====
// ----------------------------------------------------------------------------
// positional_deque_tb
// Drives opcode beats into the deque and checks every result beat against a
// mirror of the entry list. Directed beats hit the empty, range and unused
// opcode cases. Random beats then fill the deque to capacity and drain it to
// empty, over and over, under several source and sink throttling patterns.
// ----------------------------------------------------------------------------
module positional_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdq_pkg::*;

  localparam int         Capacity   = 64;
  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;
  localparam logic [6:0] PosMax     = 7'd127;

  // input beat fields, lowest bit first: opcode, value, position
  typedef struct packed {
    logic [6:0]  pos;
    logic [31:0] val;
    logic [3:0]  op;
  } deque_op_t;

  // result beat fields, lowest bit first: read data, status, count, empty
  typedef struct packed {
    logic        is_empty;
    logic [6:0]  count;
    logic [1:0]  status;
    logic [31:0] rdata;
  } deque_result_t;

  class deque_mirror;
    logic [31:0]   cells [Capacity];
    int unsigned   fill;
    deque_result_t pending_results [$];
    int unsigned   errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_op(deque_op_t item);
      deque_result_t r;
      bit            full;
      bit            empty;
      int            k;
      full  = fill >= Capacity;
      empty = fill == 0;
      r     = '0;
      r.status = StOk;
      case (item.op)
        OpPushBack, OpPushFront, OpInsertAt: begin
          if (full) begin
            r.status = StFull;
          end else if (item.op == OpInsertAt && item.pos > fill) begin
            r.status = StRange;
          end else begin
            k = (item.op == OpPushBack) ? fill : (item.op == OpPushFront) ? 0 : item.pos;
            for (int j = fill; j > k; j--) cells[j] = cells[j-1];
            cells[k] = item.val;
            fill++;
          end
        end
        OpPopFront, OpPopBack, OpRemoveAt: begin
          if (empty) begin
            r.status = StEmpty;
          end else if (item.op == OpRemoveAt && item.pos >= fill) begin
            r.status = StRange;
          end else begin
            k = (item.op == OpPopFront) ? 0 : (item.op == OpPopBack) ? fill - 1 : item.pos;
            for (int j = k; j + 1 < fill; j++) cells[j] = cells[j+1];
            fill--;
          end
        end
        OpReadFront, OpReadBack, OpReadAt: begin
          if (empty) begin
            r.status = StEmpty;
          end else if (item.op == OpReadAt && item.pos >= fill) begin
            r.status = StRange;
          end else begin
            k = (item.op == OpReadFront) ? 0 : (item.op == OpReadBack) ? fill - 1 : item.pos;
            r.rdata = cells[k];
          end
        end
        default: begin
        end
      endcase
      r.count    = fill[6:0];
      r.is_empty = (fill == 0);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      compare("read_data", want.rdata, got.rdata);
      compare("status", want.status, got.status);
      compare("entry_count", want.count, got.count);
      compare("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [pdq_pkg::InTdataW-1:0]  s_axis_tdata_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [pdq_pkg::OutTdataW-1:0] m_axis_tdata_o;

  deque_mirror mirror;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          filling;
  int unsigned linger;

  pdq_op_e grow_ops [3]   = '{OpPushBack, OpPushFront, OpInsertAt};
  pdq_op_e shrink_ops [3] = '{OpPopFront, OpPopBack, OpRemoveAt};
  pdq_op_e read_ops [3]   = '{OpReadFront, OpReadBack, OpReadAt};

  int unsigned src_phase_pct [5]  = '{0, 88, 0, 6, 0};
  int unsigned sink_phase_pct [5] = '{0, 0, 88, 6, 0};

  // pos, value, opcode
  deque_op_t directed_ops [25] = '{
    '{7'd0,   32'h0000_0000, OpReadFront},
    '{7'd0,   32'h0000_0000, OpPopFront},
    '{7'd0,   32'h0000_0000, OpPopBack},
    '{7'd0,   32'h0000_0000, OpReadBack},
    '{PosMax, 32'h0000_0000, OpRemoveAt},
    '{7'd0,   32'h0000_0000, OpReadAt},
    '{7'd1,   32'hDEAD_BEEF, OpInsertAt},
    '{7'd0,   32'h0000_0000, OpInsertAt},
    '{7'd0,   32'hFFFF_FFFF, OpPushBack},
    '{7'd0,   32'hA5A5_5A5A, OpPushFront},
    '{7'd3,   32'h1234_5678, OpInsertAt},
    '{7'd2,   32'h0000_FFFF, OpInsertAt},
    '{PosMax, 32'h0000_0001, OpInsertAt},
    '{7'd4,   32'h0000_0000, OpReadAt},
    '{7'd5,   32'h0000_0000, OpReadAt},
    '{PosMax, 32'h0000_0000, OpReadAt},
    '{7'd5,   32'h0000_0000, OpRemoveAt},
    '{7'd1,   32'h0000_0000, OpRemoveAt},
    '{7'd0,   32'h0000_0000, OpReadFront},
    '{7'd0,   32'h0000_0000, OpReadBack},
    '{PosMax, 32'hFFFF_FFFF, OpUnusedHi},
    '{7'd0,   32'h0000_0000, OpUnusedLo},
    '{7'd0,   32'h0000_0000, OpPopBack},
    '{7'd0,   32'h0000_0000, OpPopFront},
    '{7'd0,   32'h0000_0000, OpRemoveAt}
  };

  positional_deque u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) mirror.note_op(s_axis_tdata_i[42:0]);
      if (m_axis_tvalid_o && m_axis_tready_i) mirror.check_result(m_axis_tdata_o[41:0]);
    end
  end

  // called just after a falling edge; returns at the edge that takes the beat
  task automatic send_op(deque_op_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(pdq_pkg::InTdataW - $bits(deque_op_t)){1'b0}}, item};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (mirror.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // mostly grows toward capacity or shrinks toward empty, then flips
  function automatic deque_op_t next_random_op();
    deque_op_t   item;
    int unsigned roll;
    int unsigned fill;
    fill = mirror.fill;
    if ((filling && fill == Capacity) || (!filling && fill == 0)) begin
      filling = !filling;
      linger  = $urandom_range(8, 3);
    end
    roll = $urandom_range(99);
    if (linger != 0) begin
      linger--;
      item.op = 4'($urandom_range(int'(OpReadAt)));
    end else if (roll < 70) begin
      item.op = filling ? grow_ops[$urandom_range(2)] : shrink_ops[$urandom_range(2)];
    end else if (roll < 80) begin
      item.op = filling ? shrink_ops[$urandom_range(2)] : grow_ops[$urandom_range(2)];
    end else if (roll < 95) begin
      item.op = read_ops[$urandom_range(2)];
    end else begin
      item.op = 4'($urandom_range(OpUnusedHi, OpUnusedLo));
    end
    roll = $urandom_range(99);
    item.val = (roll < 5) ? 32'h0 : (roll < 10) ? 32'hFFFF_FFFF : $urandom;
    if ($urandom_range(99) < 15) begin
      item.pos = 7'($urandom_range(PosMax));
    end else if (item.op == OpInsertAt) begin
      item.pos = 7'($urandom_range(fill));
    end else begin
      item.pos = 7'($urandom_range(fill == 0 ? 0 : fill - 1));
    end
    return item;
  endfunction

  initial begin
    mirror          = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    filling         = 1'b1;
    linger          = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i]) begin
      @(negedge clk_i);
      send_op(directed_ops[i]);
    end
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      src_idle_pct   = src_phase_pct[phase];
      sink_stall_pct = sink_phase_pct[phase];
      repeat (140) begin
        @(negedge clk_i);
        send_op(next_random_op());
      end
      settle();
    end

    sink_stall_pct = 0;
    repeat (4) @(negedge clk_i);
    if (mirror.pending_results.size() != 0) begin
      mirror.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               mirror.pending_results.size());
    end
    if (mirror.errors == 0) begin
      $display("PASS positional_deque");
    end else begin
      $display("FAIL positional_deque");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("FAIL positional_deque");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pdq_pkg.sv
hw/rtl/pdq_cell.sv
hw/rtl/positional_deque.sv
tb/sv/positional_deque_tb.sv
